FILE: sv/saes_pkg.sv
// ----------------------------------------------------------------------------
// saes_pkg
// Types, constants and round functions of the small-scale nibble AES cipher.
// ----------------------------------------------------------------------------
package saes_pkg;

    localparam int ROUNDS = 5;
    localparam int NIBBLES = 16;
    localparam int BLOCK_W = 4 * NIBBLES;

    typedef logic [BLOCK_W-1:0] t_block;
    typedef logic [3:0]         t_nibble;

    // nibble s-box
    function automatic t_nibble sbox(input t_nibble v);
        t_nibble r;
        case (v)
            4'h0: r = 4'h6;
            4'h1: r = 4'hB;
            4'h2: r = 4'h5;
            4'h3: r = 4'h4;
            4'h4: r = 4'h2;
            4'h5: r = 4'hE;
            4'h6: r = 4'h7;
            4'h7: r = 4'hA;
            4'h8: r = 4'h9;
            4'h9: r = 4'hD;
            4'hA: r = 4'hF;
            4'hB: r = 4'hC;
            4'hC: r = 4'h3;
            4'hD: r = 4'h1;
            4'hE: r = 4'h0;
            4'hF: r = 4'h8;
            default: r = 4'h0;
        endcase
        return r;
    endfunction

    // multiply by x modulo x^4+x+1
    function automatic t_nibble xtime(input t_nibble v);
        return {v[2:0], 1'b0} ^ (v[3] ? 4'h3 : 4'h0);
    endfunction

    // round constant x^r, evaluated at elaboration
    function automatic t_nibble round_const(input int r);
        t_nibble c;
        c = 4'h1;
        for (int i = 0; i < r; i++) begin
            c = xtime(c);
        end
        return c;
    endfunction

    function automatic t_block next_round_key(input t_block k, input t_nibble rcon);
        t_nibble t [4];
        t_block  nk;
        nk = k;
        for (int i = 0; i < 4; i++) begin
            t[i] = sbox(k[4*(4*((i+1)%4)+3) +: 4]);
        end
        t[0] = t[0] ^ rcon;
        for (int i = 0; i < 4; i++) begin
            nk[4*(4*i) +: 4] = nk[4*(4*i) +: 4] ^ t[i];
        end
        // chain each column into the next
        for (int c = 1; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                nk[4*(4*i+c) +: 4] = nk[4*(4*i+c) +: 4] ^ nk[4*(4*i+c-1) +: 4];
            end
        end
        return nk;
    endfunction

    function automatic t_block sub_nibbles(input t_block s);
        t_block r;
        for (int n = 0; n < NIBBLES; n++) begin
            r[4*n +: 4] = sbox(s[4*n +: 4]);
        end
        return r;
    endfunction

    // row r rotated left by r positions
    function automatic t_block shift_rows(input t_block s);
        t_block r;
        for (int i = 0; i < 4; i++) begin
            for (int c = 0; c < 4; c++) begin
                r[4*(4*i+c) +: 4] = s[4*(4*i+((c+i)%4)) +: 4];
            end
        end
        return r;
    endfunction

    // circulant (x, x+1, 1, 1) over each column
    function automatic t_block mix_columns(input t_block s);
        t_block  r;
        t_nibble a0, a1, a2, a3, x0, x1, x2, x3;
        for (int c = 0; c < 4; c++) begin
            a0 = s[4*c +: 4];
            a1 = s[4*(4+c) +: 4];
            a2 = s[4*(8+c) +: 4];
            a3 = s[4*(12+c) +: 4];
            x0 = xtime(a0);
            x1 = xtime(a1);
            x2 = xtime(a2);
            x3 = xtime(a3);
            r[4*c +: 4]      = x0 ^ x1 ^ a1 ^ a2 ^ a3;
            r[4*(4+c) +: 4]  = a0 ^ x1 ^ x2 ^ a2 ^ a3;
            r[4*(8+c) +: 4]  = a0 ^ a1 ^ x2 ^ x3 ^ a3;
            r[4*(12+c) +: 4] = x0 ^ a0 ^ a1 ^ a2 ^ x3;
        end
        return r;
    endfunction

    function automatic t_block cipher_round(input t_block s, input t_block k,
                                            input logic last);
        t_block r;
        r = shift_rows(sub_nibbles(s));
        if (!last) begin
            r = mix_columns(r);
        end
        return r ^ k;
    endfunction

endpackage

FILE: sv/small_aes_nibble_encrypt_unit.sv
// ----------------------------------------------------------------------------
// small_aes_nibble_encrypt_unit
// Small-scale nibble AES encryption of 64-bit blocks under a 64-bit key.
// ----------------------------------------------------------------------------
// Takes one plaintext request per cycle unless the output stalls: the
// request is captured in an input register, all rounds run in one
// combinational pass, and the ciphertext sits in an output register until
// taken. Throughput is one block per cycle without output stalls, set by the
// single pass from the input register to the output register. Round keys are
// expanded once when the key is written and held in registers; the key write
// must happen while no request is in flight. The key port is always ready.
module small_aes_nibble_encrypt_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  saes_pkg::t_block i_cipher_key,
    input  logic             i_valid,
    output logic             o_ready,
    input  saes_pkg::t_block i_plaintext_block,
    output logic             o_valid,
    input  logic             i_ready,
    output saes_pkg::t_block o_ciphertext_block
);
    import saes_pkg::*;

    t_block r_round_key [ROUNDS+1];
    t_block n_round_key [ROUNDS+1];
    t_block w_key_src;
    logic   w_key_load;

    logic   r_in_valid;
    t_block r_in_data;
    logic   r_out_valid;
    t_block r_out_data;
    logic   w_advance;
    t_block w_state [ROUNDS+1];

    assign o_cfg_ready = 1'b1;

    // reset loads the expansion of the all-zero key
    assign w_key_src  = i_rst_n ? i_cipher_key : '0;
    assign w_key_load = !i_rst_n || i_cfg_valid;

    assign n_round_key[0] = w_key_src;
    assign w_state[0]     = r_in_data ^ r_round_key[0];

    for (genvar g = 0; g < ROUNDS; g++) begin : g_round
        localparam t_nibble RCON = round_const(g);
        assign n_round_key[g+1] = next_round_key(n_round_key[g], RCON);
        assign w_state[g+1]     = cipher_round(w_state[g], r_round_key[g+1],
                                               (g == ROUNDS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (w_key_load) begin
            for (int r = 0; r <= ROUNDS; r++) begin
                r_round_key[r] <= n_round_key[r];
            end
        end
    end

    // output register frees up when empty or taken this cycle
    assign w_advance = !r_out_valid || i_ready;
    assign o_ready   = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data <= i_plaintext_block;
        end
        if (w_advance && r_in_valid) begin
            r_out_data <= w_state[ROUNDS];
        end
    end

    assign o_valid            = r_out_valid;
    assign o_ciphertext_block = r_out_data;

endmodule

FILE: dv/tb_small_aes_nibble_encrypt_unit.sv
// ----------------------------------------------------------------------------
// tb_small_aes_nibble_encrypt_unit
// Self-checking bench for the small-scale nibble AES encryption unit.
// ----------------------------------------------------------------------------
// Sends plaintext requests over the valid/ready input and collects ciphertexts
// from the output channel. Each accepted request is encrypted by a local
// model of the cipher under the key last written, and every returned
// ciphertext is compared in order. The run covers the reset key, extreme and
// random keys, sender gaps, receiver stalls and a long receiver hold-off. It
// ends with a back-to-back stream that has no idling on either side.
// ----------------------------------------------------------------------------
module tb_small_aes_nibble_encrypt_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 250;
    // s-box output for input v sits in bits 4v+3..4v
    localparam logic [63:0] SBOX_NIBBLES = 64'h8013_CFD9_A7E2_45B6;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    saes_pkg::t_block i_cipher_key = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    saes_pkg::t_block i_plaintext_block = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    saes_pkg::t_block o_ciphertext_block;

    saes_pkg::t_block key_model = '0;
    saes_pkg::t_block pending_plaintext [$];
    saes_pkg::t_block pending_ciphertext [$];

    int  blocks_sent = 0;
    int  blocks_checked = 0;
    int  key_writes = 0;
    int  errors = 0;
    int  cycle_count = 0;
    int  rx_hold_cycles = 0;
    bit  rx_stalls = 1'b0;
    bit  tx_gaps = 1'b0;

    small_aes_nibble_encrypt_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cipher_key       (i_cipher_key),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_plaintext_block  (i_plaintext_block),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_ciphertext_block (o_ciphertext_block)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d of %0d blocks checked",
                     $time, cycle_count, blocks_checked, blocks_sent);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // cipher model
    // ------------------------------------------------------------------
    function automatic logic [3:0] subst(input logic [3:0] v);
        return SBOX_NIBBLES[4*v +: 4];
    endfunction

    // multiply by x in GF(16), x^4 = x + 1
    function automatic logic [3:0] mul_x(input logic [3:0] v);
        return {v[2:0], 1'b0} ^ {2'b00, v[3], v[3]};
    endfunction

    function automatic saes_pkg::t_block encrypt_block(input saes_pkg::t_block pt,
                                                       input saes_pkg::t_block key);
        logic [3:0]       st [16];
        logic [3:0]       rk [16];
        logic [3:0]       rot [16];
        logic [3:0]       kcol [4];
        logic [3:0]       rc, a0, a1, a2, a3;
        saes_pkg::t_block ct;
        rc = 4'h1;
        for (int n = 0; n < 16; n++) begin
            rk[n] = key[4*n +: 4];
            st[n] = pt[4*n +: 4] ^ rk[n];
        end
        for (int r = 0; r < saes_pkg::ROUNDS; r++) begin
            // round key: rotated, substituted column 3 into column 0, then chain
            for (int i = 0; i < 4; i++) begin
                kcol[i] = subst(rk[4*((i+1)%4)+3]);
            end
            kcol[0] = kcol[0] ^ rc;
            for (int i = 0; i < 4; i++) begin
                rk[4*i] = rk[4*i] ^ kcol[i];
            end
            for (int c = 1; c < 4; c++) begin
                for (int i = 0; i < 4; i++) begin
                    rk[4*i+c] = rk[4*i+c] ^ rk[4*i+c-1];
                end
            end
            rc = mul_x(rc);
            for (int i = 0; i < 4; i++) begin
                for (int c = 0; c < 4; c++) begin
                    rot[4*i+c] = subst(st[4*i+((c+i)%4)]);
                end
            end
            if (r != saes_pkg::ROUNDS - 1) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = rot[c];
                    a1 = rot[4+c];
                    a2 = rot[8+c];
                    a3 = rot[12+c];
                    st[c]    = mul_x(a0) ^ mul_x(a1) ^ a1 ^ a2 ^ a3;
                    st[4+c]  = a0 ^ mul_x(a1) ^ mul_x(a2) ^ a2 ^ a3;
                    st[8+c]  = a0 ^ a1 ^ mul_x(a2) ^ mul_x(a3) ^ a3;
                    st[12+c] = mul_x(a0) ^ a0 ^ a1 ^ a2 ^ mul_x(a3);
                end
            end else begin
                for (int n = 0; n < 16; n++) begin
                    st[n] = rot[n];
                end
            end
            for (int n = 0; n < 16; n++) begin
                st[n] = st[n] ^ rk[n];
            end
        end
        for (int n = 0; n < 16; n++) begin
            ct[4*n +: 4] = st[n];
        end
        return ct;
    endfunction

    // ------------------------------------------------------------------
    // ciphertext checking and request capture
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_ciphertext
        saes_pkg::t_block want, pt;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_ciphertext.size() == 0) begin
                    errors++;
                    $display("%0t: ciphertext %h with no request pending",
                             $time, o_ciphertext_block);
                end else begin
                    want = pending_ciphertext.pop_front();
                    pt = pending_plaintext.pop_front();
                    blocks_checked++;
                    if (o_ciphertext_block !== want) begin
                        errors++;
                        $display("%0t: plaintext %h: expected %h actual %h",
                                 $time, pt, want, o_ciphertext_block);
                    end
                end
            end
            if (i_valid && o_ready) begin
                pending_plaintext.push_back(i_plaintext_block);
                pending_ciphertext.push_back(encrypt_block(i_plaintext_block, key_model));
            end
            if (i_cfg_valid && o_cfg_ready) begin
                key_model = i_cipher_key;
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall bursts and an optional long hold-off
    // ------------------------------------------------------------------
    initial begin : receiver
        int n;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                i_ready <= 1'b0;
                while (rx_hold_cycles > 0) begin
                    @(posedge i_clk);
                    rx_hold_cycles--;
                end
            end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                n = $urandom_range(1, 20);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side helpers
    // ------------------------------------------------------------------
    task automatic send_block(input saes_pkg::t_block pt);
        i_valid <= 1'b1;
        i_plaintext_block <= pt;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        blocks_sent++;
    endtask

    task automatic wait_all_returned();
        i_valid <= 1'b0;
        while (blocks_checked < blocks_sent) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_key(input saes_pkg::t_block k);
        wait_all_returned();
        i_cfg_valid <= 1'b1;
        i_cipher_key <= k;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        key_writes++;
    endtask

    function automatic saes_pkg::t_block random_plaintext();
        saes_pkg::t_block pt;
        case ($urandom_range(0, 9))
            0:       pt = 64'd1 << $urandom_range(0, 63);
            1:       pt = ~(64'd1 << $urandom_range(0, 63));
            default: pt = {$urandom, $urandom};
        endcase
        return pt;
    endfunction

    function automatic saes_pkg::t_block random_key();
        return {$urandom, $urandom};
    endfunction

    task automatic send_random_blocks(input int count);
        int n;
        for (int i = 0; i < count; i++) begin
            if (tx_gaps && $urandom_range(0, 5) == 0) begin
                i_valid <= 1'b0;
                n = $urandom_range(1, 13);
                repeat (n) @(posedge i_clk);
            end
            send_block(random_plaintext());
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // all-zero key straight out of reset, every nibble value in every position
    task automatic test_reset_key();
        saes_pkg::t_block pt;
        for (int v = 0; v < 16; v++) begin
            pt = {16{v[3:0]}};
            send_block(pt);
        end
        send_block(64'h0123_4567_89AB_CDEF);
        send_block(64'hFEDC_BA98_7654_3210);
    endtask

    task automatic test_key_extremes();
        write_key('1);
        send_block('0);
        send_block('1);
        send_block(64'h0123_4567_89AB_CDEF);
        write_key(64'hA5A5_A5A5_A5A5_A5A5);
        send_block(64'h5A5A_5A5A_5A5A_5A5A);
        send_block('0);
    endtask

    task automatic test_random_traffic();
        rx_stalls = 1'b1;
        tx_gaps = 1'b1;
        write_key('0);
        send_random_blocks(300);
        for (int p = 0; p < 3; p++) begin
            write_key(random_key());
            send_random_blocks(300);
        end
    endtask

    // receiver holds off while the sender keeps offering requests
    task automatic test_output_backpressure();
        write_key(random_key());
        rx_stalls = 1'b0;
        tx_gaps = 1'b0;
        rx_hold_cycles = HOLD_CYCLES;
        send_random_blocks(60);
    endtask

    task automatic test_full_rate();
        write_key(random_key());
        rx_stalls = 1'b0;
        tx_gaps = 1'b0;
        send_random_blocks(350);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_key();
        test_key_extremes();
        test_random_traffic();
        test_output_backpressure();
        test_full_rate();
        wait_all_returned();

        if (pending_ciphertext.size() != 0) begin
            errors += pending_ciphertext.size();
            $display("%0t: %0d ciphertexts never returned", $time,
                     pending_ciphertext.size());
        end
        $display("encrypted %0d blocks under %0d key writes plus the reset key",
                 blocks_sent, key_writes);
        $display("with sender gaps, receiver stalls and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/saes_pkg.sv
sv/small_aes_nibble_encrypt_unit.sv
dv/tb_small_aes_nibble_encrypt_unit.sv
